>>> rtl/core/rms_block_level_meter_top_assert.svh
// ----------------------------------------------------------------------------
// rms block level meter assertion macros
// shared helpers for the concurrent checks on the level meter
// ----------------------------------------------------------------------------
`ifndef RMS_BLOCK_LEVEL_METER_TOP_ASSERT_SVH
`define RMS_BLOCK_LEVEL_METER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rms_pkg.sv
// ----------------------------------------------------------------------------
// rms_pkg
// widths, register codes, state types and the half-sine band weight table
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 16;
  localparam int SQ_W       = 31;
  localparam int SUM_W      = 46;
  localparam int CNT_W      = 16;
  localparam int BLEN_W     = 16;
  localparam int GAIN_W     = 8;
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int RMS_W      = 16;
  localparam int REM_W      = 18;
  localparam int SUB_W      = 20;
  localparam int RAD_W      = 32;
  localparam int LEVEL_W    = 16;
  localparam int BIDX_W     = 4;
  localparam int P1_W       = 31;
  localparam int P2_W       = 38;
  localparam int ROUND_SH   = 19;

  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam int BAND_COUNT = 16;
  localparam int BAND_W     = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;

  localparam logic [BLEN_W-1:0]  BLEN_RESET = 16'd1024;
  localparam logic [GAIN_W-1:0]  GAIN_RESET = 8'd80;
  localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'h8000;
  localparam logic [63:0]        PI_Q30     = 64'd3373259426;

  localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_LENGTH = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_GAIN   = 1'b1;

  typedef enum logic [1:0] {ACC_IDLE, ACC_SQ, ACC_ADD} acc_state_t;
  typedef enum logic [1:0] {RT_IDLE, RT_DIV, RT_SQRT} root_state_t;
  typedef enum logic [1:0] {BD_IDLE, BD_MUL1, BD_MUL2, BD_EMIT} band_state_t;

  typedef struct packed {
    logic busy;
    logic blk_end;
  } acc_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

  typedef logic [LEVEL_W-1:0] weight_tab_t [BAND_COUNT];

  localparam logic [7:0] TAYLOR_DIV [5] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110};

  // sin(pi*i/n) in unsigned q1.15 by truncated taylor series, elaboration only
  function automatic weight_tab_t build_weights();
    weight_tab_t        tab;
    logic [63:0]        j;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        rnd;
    logic signed [63:0] acc;
    for (int i = 0; i < BAND_COUNT; i++) begin
      j = 64'(i);
      if (64'(BAND_COUNT - i) < j) begin
        j = 64'(BAND_COUNT - i);
      end
      x    = (PI_Q30 * j) / BAND_COUNT;
      x2   = (x * x) >> 30;
      term = x;
      acc  = signed'(x);
      for (int k = 1; k <= 5; k++) begin
        term = (term * x2) >> 30;
        term = term / 64'(TAYLOR_DIV[k-1]);
        if (k[0]) begin
          acc = acc - signed'(term);
        end else begin
          acc = acc + signed'(term);
        end
      end
      if (acc <= 0) begin
        tab[i] = '0;
      end else begin
        rnd = (64'(acc) + (64'd1 << 14)) >> 15;
        tab[i] = (rnd > 64'(FULL_SCALE)) ? FULL_SCALE : LEVEL_W'(rnd);
      end
    end
    return tab;
  endfunction

  localparam weight_tab_t WEIGHTS = build_weights();

endpackage

>>> rtl/core/rms_block_level_meter_top.sv
// ----------------------------------------------------------------------------
// rms_block_level_meter_top
// block rms level meter with a half-sine weighted bar display
// ----------------------------------------------------------------------------
// A sample word passes through the accumulator sequence (accept, square,
// add). The sample that completes a block then goes through a handoff into
// the divider, 46 restoring-division steps for the mean, 16 square-root
// steps and a handoff to the band stage; the division and square-root steps
// share one 20-bit subtractor. The 16 band words then follow, each through
// two multiplies and the rounding stage, which waits out any output stall.
// No new sample is taken until the last band word is in the output register;
// that word may wait there while samples flow again.
module rms_block_level_meter_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [rms_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic        [rms_pkg::BIDX_W-1:0]     out_band_index,
  output logic        [rms_pkg::LEVEL_W-1:0]    out_level,
  output logic                                  out_last_band,
  input  logic                                  cfg_we,
  input  logic        [rms_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic        [rms_pkg::CFG_W-1:0]      cfg_wdata
);
  import rms_pkg::*;

  logic [BLEN_W-1:0] blen_r, blen_nxt;
  logic [GAIN_W-1:0] gain_r, gain_nxt;

  acc_stat_t         acc_stat;
  root_stat_t        root_stat;
  logic              band_busy;
  logic [SUM_W-1:0]  fin_sum;
  logic [CNT_W-1:0]  fin_cnt;
  logic [RMS_W-1:0]  rms;
  logic              take;

  always_comb begin
    blen_nxt = blen_r;
    gain_nxt = gain_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_BLOCK_LENGTH: blen_nxt = cfg_wdata[BLEN_W-1:0];
        REG_LEVEL_GAIN:   gain_nxt = cfg_wdata[GAIN_W-1:0];
        default: begin
          blen_nxt = blen_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blen_r <= BLEN_RESET;
      gain_r <= GAIN_RESET;
    end else begin
      blen_r <= blen_nxt;
      gain_r <= gain_nxt;
    end
  end

  assign in_stall = acc_stat.busy || root_stat.busy || band_busy;
  assign take     = in_valid && !in_stall;

  rms_acc u_acc (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .sample       (in_sample),
    .block_length (blen_r),
    .stat         (acc_stat),
    .fin_sum      (fin_sum),
    .fin_cnt      (fin_cnt)
  );

  rms_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (acc_stat.blk_end),
    .sum   (fin_sum),
    .cnt   (fin_cnt),
    .stat  (root_stat),
    .rms   (rms)
  );

  rms_band u_band (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (root_stat.done),
    .rms            (rms),
    .gain           (gain_r),
    .busy           (band_busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_band_index (out_band_index),
    .out_level      (out_level),
    .out_last_band  (out_last_band)
  );

endmodule

>>> rtl/core/rms_acc.sv
// ----------------------------------------------------------------------------
// rms_acc
// squares each sample, sums the squares and counts samples until block end
// ----------------------------------------------------------------------------
module rms_acc (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 take,
  input  logic signed [rms_pkg::SAMPLE_W-1:0]  sample,
  input  logic        [rms_pkg::BLEN_W-1:0]    block_length,
  output rms_pkg::acc_stat_t                   stat,
  output logic        [rms_pkg::SUM_W-1:0]     fin_sum,
  output logic        [rms_pkg::CNT_W-1:0]     fin_cnt
);
  import rms_pkg::*;

  acc_state_t         state_r, state_nxt;
  logic [MAG_W-1:0]   mag_r, mag_nxt;
  logic [SQ_W-1:0]    sq_r, sq_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SUM_W-1:0]   fin_sum_r, fin_sum_nxt;
  logic [CNT_W-1:0]   fin_cnt_r, fin_cnt_nxt;
  logic               end_r, end_nxt;

  logic [SUM_W-1:0]   sum_add;
  logic [CNT_W-1:0]   cnt_inc;
  logic [BLEN_W-1:0]  limit;
  logic               blk_done;
  logic [2*MAG_W-1:0] sq_full;

  assign sum_add  = sum_r + SUM_W'(sq_r);
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign limit    = (block_length == '0) ? BLEN_W'(1) : block_length;
  assign blk_done = (cnt_inc != '0) && (cnt_inc >= limit);
  assign sq_full  = (2*MAG_W)'(mag_r) * (2*MAG_W)'(mag_r);

  always_comb begin
    state_nxt   = state_r;
    mag_nxt     = mag_r;
    sq_nxt      = sq_r;
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    fin_sum_nxt = fin_sum_r;
    fin_cnt_nxt = fin_cnt_r;
    end_nxt     = 1'b0;
    unique case (state_r)
      ACC_IDLE: begin
        if (take) begin
          mag_nxt   = sample[SAMPLE_W-1] ? MAG_W'(-sample) : MAG_W'(sample);
          state_nxt = ACC_SQ;
        end
      end
      ACC_SQ: begin
        sq_nxt    = sq_full[SQ_W-1:0];
        state_nxt = ACC_ADD;
      end
      ACC_ADD: begin
        if (blk_done) begin
          fin_sum_nxt = sum_add;
          fin_cnt_nxt = cnt_inc;
          sum_nxt     = '0;
          cnt_nxt     = '0;
          end_nxt     = 1'b1;
        end else begin
          sum_nxt = sum_add;
          cnt_nxt = cnt_inc;
        end
        state_nxt = ACC_IDLE;
      end
      default: begin
        state_nxt = ACC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ACC_IDLE;
      sum_r   <= '0;
      cnt_r   <= '0;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      end_r   <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    sq_r      <= sq_nxt;
    fin_sum_r <= fin_sum_nxt;
    fin_cnt_r <= fin_cnt_nxt;
  end

  assign stat.busy    = (state_r != ACC_IDLE) || end_r;
  assign stat.blk_end = end_r;
  assign fin_sum      = fin_sum_r;
  assign fin_cnt      = fin_cnt_r;

endmodule

>>> rtl/core/rms_root.sv
// ----------------------------------------------------------------------------
// rms_root
// mean by restoring division then integer square root, one shared subtractor
// ----------------------------------------------------------------------------
module rms_root (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rms_pkg::SUM_W-1:0]     sum,
  input  logic [rms_pkg::CNT_W-1:0]     cnt,
  output rms_pkg::root_stat_t           stat,
  output logic [rms_pkg::RMS_W-1:0]     rms
);
  import rms_pkg::*;

  root_state_t        state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [SUM_W-1:0]   src_r, src_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [RMS_W-1:0]   root_r, root_nxt;
  logic [CNT_W-1:0]   dvs_r, dvs_nxt;
  logic [RMS_W-1:0]   rms_r, rms_nxt;
  logic               done_r, done_nxt;

  logic [SUB_W-1:0]   sub_a;
  logic [SUB_W-1:0]   sub_b;
  logic [SUB_W:0]     sub_d;
  logic               sub_ok;
  logic [SUM_W-1:0]   quo_shift;

  // shared subtract and compare
  assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ok = !sub_d[SUB_W];

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    unique case (state_r)
      RT_DIV: begin
        sub_a = SUB_W'({rem_r[CNT_W-1:0], src_r[SUM_W-1]});
        sub_b = SUB_W'(dvs_r);
      end
      RT_SQRT: begin
        sub_a = {rem_r, src_r[SUM_W-1:SUM_W-2]};
        sub_b = SUB_W'({root_r, 2'b01});
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign quo_shift = {src_r[SUM_W-2:0], sub_ok};

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    src_nxt   = src_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    dvs_nxt   = dvs_r;
    rms_nxt   = rms_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      RT_IDLE: begin
        if (start) begin
          src_nxt   = sum;
          dvs_nxt   = cnt;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = RT_DIV;
        end
      end
      RT_DIV: begin
        rem_nxt  = sub_ok ? REM_W'(sub_d[CNT_W-1:0]) : REM_W'(sub_a[CNT_W-1:0]);
        src_nxt  = quo_shift;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          // mean never exceeds 2^30, low word is the radicand
          src_nxt   = {quo_shift[RAD_W-1:0], (SUM_W-RAD_W)'(0)};
          rem_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          state_nxt = RT_SQRT;
        end
      end
      RT_SQRT: begin
        rem_nxt  = sub_ok ? sub_d[REM_W-1:0] : sub_a[REM_W-1:0];
        root_nxt = {root_r[RMS_W-2:0], sub_ok};
        src_nxt  = {src_r[SUM_W-3:0], 2'b00};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SQRT_STEPS - 1)) begin
          rms_nxt   = {root_r[RMS_W-2:0], sub_ok};
          done_nxt  = 1'b1;
          state_nxt = RT_IDLE;
        end
      end
      default: begin
        state_nxt = RT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RT_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r  <= src_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    dvs_r  <= dvs_nxt;
    rms_r  <= rms_nxt;
  end

  assign stat.busy = (state_r != RT_IDLE) || done_r;
  assign stat.done = done_r;
  assign rms       = rms_r;

endmodule

>>> rtl/core/rms_band.sv
// ----------------------------------------------------------------------------
// rms_band
// scales rms by the band weight and gain, rounds, saturates, emits each band
// ----------------------------------------------------------------------------
module rms_band (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [rms_pkg::RMS_W-1:0]       rms,
  input  logic [rms_pkg::GAIN_W-1:0]      gain,
  output logic                            busy,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rms_pkg::BIDX_W-1:0]      out_band_index,
  output logic [rms_pkg::LEVEL_W-1:0]     out_level,
  output logic                            out_last_band
);
  import rms_pkg::*;

  band_state_t         state_r, state_nxt;
  logic [BAND_W-1:0]   idx_r, idx_nxt;
  logic [P1_W-1:0]     p1_r, p1_nxt;
  logic [P2_W-1:0]     p2_r, p2_nxt;
  logic                ov_r, ov_nxt;
  logic [BIDX_W-1:0]   ob_r, ob_nxt;
  logic [LEVEL_W-1:0]  ol_r, ol_nxt;
  logic                olast_r, olast_nxt;

  logic [2*RMS_W-1:0]  mul1;
  logic [P2_W-1:0]     mul2;
  logic [P2_W:0]       rnd;
  logic [P2_W-ROUND_SH:0] lvl_raw;
  logic [LEVEL_W-1:0]  lvl;
  logic                is_last;
  logic [6:0]          idx_wide;
  logic                slot_free;

  assign mul1      = (2*RMS_W)'(rms) * (2*RMS_W)'(WEIGHTS[idx_r]);
  assign mul2      = P2_W'(p1_r) * P2_W'(gain);
  assign rnd       = {1'b0, p2_r} + ((P2_W+1)'(1) << (ROUND_SH - 1));
  assign lvl_raw   = rnd[P2_W:ROUND_SH];
  assign lvl       = (lvl_raw > (P2_W-ROUND_SH+1)'(FULL_SCALE)) ? FULL_SCALE
                                                               : lvl_raw[LEVEL_W-1:0];
  assign is_last   = (idx_r == BAND_W'(BAND_COUNT - 1));
  assign idx_wide  = 7'(idx_r);
  assign slot_free = !ov_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    ov_nxt    = ov_r && out_stall;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    olast_nxt = olast_r;
    unique case (state_r)
      BD_IDLE: begin
        if (start) begin
          idx_nxt   = '0;
          state_nxt = BD_MUL1;
        end
      end
      BD_MUL1: begin
        p1_nxt    = mul1[P1_W-1:0];
        state_nxt = BD_MUL2;
      end
      BD_MUL2: begin
        p2_nxt    = mul2;
        state_nxt = BD_EMIT;
      end
      BD_EMIT: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = idx_wide[BIDX_W-1:0];
          ol_nxt    = lvl;
          olast_nxt = is_last;
          if (is_last) begin
            state_nxt = BD_IDLE;
          end else begin
            idx_nxt   = idx_r + BAND_W'(1);
            state_nxt = BD_MUL1;
          end
        end
      end
      default: begin
        state_nxt = BD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BD_IDLE;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_r    <= p1_nxt;
    p2_r    <= p2_nxt;
    ob_r    <= ob_nxt;
    ol_r    <= ol_nxt;
    olast_r <= olast_nxt;
  end

  assign busy           = (state_r != BD_IDLE);
  assign out_valid      = ov_r;
  assign out_band_index = ob_r;
  assign out_level      = ol_r;
  assign out_last_band  = olast_r;

endmodule

>>> rtl/core/rms_chk.sv
// ----------------------------------------------------------------------------
// rms_chk
// port-level checks on the level meter, bound to the top level
// ----------------------------------------------------------------------------
module rms_chk (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic        [rms_pkg::BIDX_W-1:0]     out_band_index,
  input logic        [rms_pkg::LEVEL_W-1:0]    out_level,
  input logic                                  out_last_band
);
  import rms_pkg::*;
`include "rms_block_level_meter_top_assert.svh"

  logic [BIDX_W-1:0] last_idx;
  logic [6:0]        last_wide;

  assign last_wide = 7'(BAND_COUNT - 1);
  assign last_idx  = last_wide[BIDX_W-1:0];

  `RMS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_level) && $stable(out_band_index) && $stable(out_last_band), "stalled result word changed")

  `RMS_ASSERT_NOW(a_level_sat, out_valid, out_level <= FULL_SCALE, "level above full scale")

  `RMS_ASSERT_NOW(a_last_idx, out_valid && out_last_band, out_band_index == last_idx, "last band flag on wrong band")

  `RMS_ASSERT_NOW(a_busy_bands, out_valid && !out_last_band, in_stall, "sample taken while bands still pending")

endmodule

bind rms_block_level_meter_top rms_chk u_chk (.*);

>>> tb/rms_block_level_meter_top_tb.sv
// ----------------------------------------------------------------------------
// rms_block_level_meter_top_tb
// Self-checking bench for the block rms level meter. A driver feeds sample
// words from a queue and a monitor checks each band word against a local
// model of the squared-sum, mean, square-root and half-sine weighting path.
// Both sides idle in random bursts. The run goes through several
// block-length and gain settings, with zero length and the gain extremes
// among them.
// ----------------------------------------------------------------------------
module rms_block_level_meter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rms_pkg::*;

  localparam int              WATCHDOG_LIMIT = 4000;
  localparam int              SETTLE_CYCLES  = 150;
  localparam int              RANDOM_ITEMS   = 310;
  localparam int              FINAL_ITEMS    = 40;
  localparam longint unsigned PI_FIXED_Q30   = 64'd3373259426;

  typedef struct packed {
    logic [BIDX_W-1:0]  band;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } band_word_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_W-1:0]    in_sample = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic        [BIDX_W-1:0]      out_band_index;
  logic        [LEVEL_W-1:0]     out_level;
  logic                          out_last_band;
  logic                          cfg_we = 1'b0;
  logic        [CFG_ADDR_W-1:0]  cfg_addr = REG_BLOCK_LENGTH;
  logic        [CFG_W-1:0]       cfg_wdata = '0;

  logic signed [SAMPLE_W-1:0] sample_queue [$];
  band_word_t                 band_levels_due [$];

  logic [LEVEL_W-1:0] bar_weight [BAND_COUNT];
  logic [BLEN_W-1:0]  blen_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [SUM_W-1:0]   square_sum_q;
  logic [CNT_W-1:0]   samples_seen_q;

  logic idle_en = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   errors = 0;
  int   samples_taken = 0;
  int   blocks_ended = 0;
  int   words_checked = 0;
  int   random_items = 0;

  rms_block_level_meter_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_band_index (out_band_index),
    .out_level      (out_level),
    .out_last_band  (out_last_band),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic logic [LEVEL_W-1:0] half_sine_weight(input int bar);
    longint unsigned j;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned rounded;
    longint          acc;
    j = longint'(bar);
    if (longint'(BAND_COUNT - bar) < j) begin
      j = longint'(BAND_COUNT - bar);
    end
    x    = (PI_FIXED_Q30 * j) / longint'(BAND_COUNT);
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int k = 1; k <= 5; k++) begin
      term = (term * x2) >> 30;
      term = term / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc <= 0) begin
      return '0;
    end
    rounded = (longint'(acc) + 64'd16384) >> 15;
    return (rounded > 64'd32768) ? FULL_SCALE : LEVEL_W'(rounded);
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= v) begin
        r = trial;
      end
    end
    return r;
  endfunction

  // running square sum; a block end turns it into one word per bar
  task automatic accumulate_sample(input logic signed [SAMPLE_W-1:0] s);
    logic [16:0]     mag;
    logic [16:0]     limit;
    longint unsigned rms;
    longint unsigned prod;
    longint unsigned lvl;
    band_word_t      w;
    mag = s[SAMPLE_W-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
    square_sum_q   = square_sum_q + SUM_W'(mag) * SUM_W'(mag);
    samples_seen_q = samples_seen_q + 1'b1;
    limit = (blen_q == 0) ? 17'd1 : {1'b0, blen_q};
    if (samples_seen_q == 0 || {1'b0, samples_seen_q} < limit) begin
      return;
    end
    rms = root_floor(64'(square_sum_q) / 64'(samples_seen_q));
    for (int i = 0; i < BAND_COUNT; i++) begin
      prod = rms * 64'(bar_weight[i]) * 64'(gain_q);
      lvl  = (prod + 64'd262144) >> ROUND_SH;
      if (lvl > 64'd32768) begin
        lvl = 64'd32768;
      end
      w.band  = BIDX_W'(i);
      w.level = LEVEL_W'(lvl);
      w.last  = (i == BAND_COUNT - 1);
      band_levels_due = {band_levels_due, w};
    end
    square_sum_q   = '0;
    samples_seen_q = '0;
    blocks_ended++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        accumulate_sample(in_sample);
        samples_taken++;
      end
      if (in_valid && in_stall) begin
        // hold the word until it is taken
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        gap_left <= $urandom_range(0, 12);
        in_valid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        in_valid  <= 1'b1;
        in_sample <= sample_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    band_word_t due;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        words_checked++;
        if (band_levels_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected band word, expected none, actual band %0d level %0d last %0b",
                   $time, out_band_index, out_level, out_last_band);
        end else begin
          due = band_levels_due.pop_front();
          if (out_band_index !== due.band) begin
            errors++;
            $display("%0t: band_index mismatch, expected %0d, actual %0d",
                     $time, due.band, out_band_index);
          end
          if (out_level !== due.level) begin
            errors++;
            $display("%0t: level mismatch on band %0d, expected %0d, actual %0d",
                     $time, due.band, due.level, out_level);
          end
          if (out_last_band !== due.last) begin
            errors++;
            $display("%0t: last_band mismatch on band %0d, expected %0b, actual %0b",
                     $time, due.band, due.last, out_last_band);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 12);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_config(input logic [BLEN_W-1:0] blen, input logic [CFG_W-1:0] gain_word);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_BLOCK_LENGTH;
    cfg_wdata <= CFG_W'(blen);
    @(posedge clk);
    cfg_addr  <= REG_LEVEL_GAIN;
    cfg_wdata <= gain_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    blen_q = blen;
    gain_q = gain_word[GAIN_W-1:0];
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (sample_queue.size() != 0 || in_valid || band_levels_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'hffff;
          default: return 16'h0001;
        endcase
      end
      1, 2: begin
        return $urandom_range(0, 1) ? SAMPLE_W'($urandom_range(0, 255))
                                    : SAMPLE_W'(-$urandom_range(0, 255));
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [BLEN_W-1:0] blen;
    logic [GAIN_W-1:0] gain;
    int                n;
    for (int i = 0; i < BAND_COUNT; i++) begin
      bar_weight[i] = half_sine_weight(i);
    end
    blen_q         = BLEN_RESET;
    gain_q         = GAIN_RESET;
    square_sum_q   = '0;
    samples_seen_q = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, partial block only
    idle_en = 1'b1;
    sample_queue = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001};
    wait_idle();

    // length cut below the running count, then extremes at full gain
    set_config(16'd1, 16'h00ff);
    sample_queue = '{16'h8000, 16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff,
                     16'h5555, 16'haaaa};
    wait_idle();

    // zero gain
    set_config(16'd1, 16'h0000);
    sample_queue = '{16'd12345, 16'h8000};
    wait_idle();

    // zero length acts as one
    set_config(16'd0, 16'h0010);
    sample_queue = '{16'h7fff, 16'hffff, 16'd100};
    wait_idle();

    // gain write with upper data bits set
    set_config(16'd2, 16'hff50);
    sample_queue = '{16'h8000, 16'h7fff, 16'd7, -16'sd7};
    wait_idle();

    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:                blen = '0;
        1, 2, 3, 4, 5, 6: blen = BLEN_W'($urandom_range(1, 8));
        7, 8:             blen = BLEN_W'($urandom_range(9, 40));
        default:          blen = BLEN_W'($urandom_range(41, 120));
      endcase
      case ($urandom_range(0, 7))
        0:       gain = '0;
        1:       gain = 8'hff;
        default: gain = GAIN_W'($urandom_range(1, 254));
      endcase
      idle_en = ($urandom_range(0, 4) != 0);
      set_config(blen, {8'($urandom), gain});
      n = $urandom_range(8, 40);
      for (int k = 0; k < n; k++) begin
        sample_queue = {sample_queue, random_sample()};
      end
      random_items += n;
      wait_idle();
    end

    // back-to-back samples, mostly near full scale, no idling
    idle_en = 1'b0;
    set_config(16'd8, 16'h00ff);
    for (int k = 0; k < FINAL_ITEMS; k++) begin
      case ($urandom_range(0, 3))
        0:       sample_queue = {sample_queue, 16'h7fff};
        1:       sample_queue = {sample_queue, 16'h8001};
        2:       sample_queue = {sample_queue, 16'h8000};
        default: sample_queue = {sample_queue, random_sample()};
      endcase
    end
    wait_idle();

    $display("covered %0d samples over %0d blocks, %0d band words checked",
             samples_taken, blocks_ended, words_checked);
    $display("settings swept: block length 0 to 120, gain 0 to 255");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
